[hw/rtl/rsp_dfr_pkg.sv]
// Shared types, constants and helpers for the RSP packet deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rsp_dfr_pkg;

    // Payload buffer size; bounds the packet byte count.
    localparam int BUFFER_BYTES = 4096;
    localparam int COUNT_W      = $clog2(BUFFER_BYTES);

    // Field widths fixed by the interface.
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 12;
    localparam int MAXLEN_W = 13;

    // Configuration bus.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Width used to clamp max_length against the buffer size.
    localparam int LIM_EXT_W = (COUNT_W + 1 > MAXLEN_W) ? COUNT_W + 1 : MAXLEN_W;

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(BUFFER_BYTES);

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_ENABLE     = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } t_reg_idx;

    // Framing characters.
    localparam logic [BYTE_W-1:0] CH_START = 8'd36;  // '$'
    localparam logic [BYTE_W-1:0] CH_END   = 8'd35;  // '#'
    localparam logic [BYTE_W-1:0] CH_ACK   = 8'd43;  // '+'
    localparam logic [BYTE_W-1:0] CH_NAK   = 8'd45;  // '-'
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;  // '9'
    localparam logic [BYTE_W-1:0] CH_A_OFS = 8'd87;  // 'a' - 10

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2,
        KIND_ABANDON = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_CK_HIGH = 4'b0100,
        PH_CK_LOW  = 4'b1000
    } t_phase;

    // Live configuration handed from the register block to the engine.
    typedef struct packed {
        logic               enable;
        logic [COUNT_W-1:0] limit;   // payload count that abandons a packet
    } t_cfg;

    // Checksum digit decode: '0'..'9' -> 0..9, anything else c-87 mod 256.
    function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return c - CH_ZERO;
        end
        return c - CH_A_OFS;
    endfunction

endpackage

[hw/rtl/rsp_dfr_regs.sv]
// APB configuration registers (enable, max_length) and the derived payload limit.
// Depends on rsp_dfr_pkg.
`timescale 1ns / 1ps

module rsp_dfr_regs
    import rsp_dfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic                 r_enable;
    logic [MAXLEN_W-1:0]  r_max_length;
    logic                 wr_en;
    t_reg_idx             reg_idx;
    logic [LIM_EXT_W-1:0] max_ext;
    logic [LIM_EXT_W-1:0] clamped;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_max_length <= MAXLEN_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:     r_enable     <= pwdata[0];
                REG_MAX_LENGTH: r_max_length <= pwdata[MAXLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE:     prdata = APB_DW'(r_enable);
            REG_MAX_LENGTH: prdata = APB_DW'(r_max_length);
            default:        prdata = '0;
        endcase
    end

    // Clamp max_length to [2, BUFFER_BYTES]; the limit is one less.
    always_comb begin
        max_ext = LIM_EXT_W'(r_max_length);
        if (max_ext < LIM_EXT_W'(2)) begin
            clamped = LIM_EXT_W'(2);
        end else if (max_ext > LIM_EXT_W'(BUFFER_BYTES)) begin
            clamped = LIM_EXT_W'(BUFFER_BYTES);
        end else begin
            clamped = max_ext;
        end
    end

    assign o_cfg.enable = r_enable;
    assign o_cfg.limit  = COUNT_W'(clamped - LIM_EXT_W'(1));

endmodule

[hw/rtl/rsp_dfr_engine.sv]
// Framing engine: input register, packet state, per-byte decode and result register.
// Depends on rsp_dfr_pkg; configuration comes from rsp_dfr_regs.
`timescale 1ns / 1ps

module rsp_dfr_engine
    import rsp_dfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_rx_valid,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_rx_stall,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic [BYTE_W-1:0] o_reply_byte
);

    // input stage
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;

    // packet state
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0]  r_sum,   n_sum;
    logic [BYTE_W-1:0]  r_high,  n_high;

    // result stage
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_len;
    logic [BYTE_W-1:0] r_out_reply;

    logic               out_free;
    logic               s1_fire;
    logic               rx_accept;
    logic               res_valid;
    t_kind              res_kind;
    logic [BYTE_W-1:0]  res_byte;
    logic [LEN_W-1:0]   res_len;
    logic [BYTE_W-1:0]  res_reply;
    logic [COUNT_W-1:0] count_inc;
    logic [BYTE_W-1:0]  digit;

    assign out_free   = !r_out_valid || !i_res_stall;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_rx_stall = r_s1_valid && !out_free;
    assign rx_accept  = i_rx_valid && !o_rx_stall;

    assign count_inc = r_count + COUNT_W'(1);
    assign digit     = hex_value(r_s1_byte);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_high    = r_high;
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_byte  = '0;
        res_len   = '0;
        res_reply = '0;
        if (s1_fire) begin
            if (!i_cfg.enable) begin
                n_phase = PH_HUNT;
                n_count = '0;
                n_sum   = '0;
                n_high  = '0;
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (r_s1_byte == CH_START) begin
                            n_phase = PH_PAYLOAD;
                            n_count = '0;
                            n_sum   = '0;
                            n_high  = '0;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (r_s1_byte == CH_END) begin
                            n_phase = PH_CK_HIGH;
                        end else begin
                            res_valid = 1'b1;
                            if (count_inc >= i_cfg.limit) begin
                                // buffer full: drop the packet, report its length
                                res_kind = KIND_ABANDON;
                                res_len  = LEN_W'(count_inc);
                                n_phase  = PH_HUNT;
                                n_count  = '0;
                                n_sum    = '0;
                                n_high   = '0;
                            end else begin
                                res_byte = r_s1_byte;
                                n_count  = count_inc;
                                n_sum    = r_sum + r_s1_byte;
                            end
                        end
                    end
                    PH_CK_HIGH: begin
                        n_high  = {digit[3:0], 4'b0000};
                        n_phase = PH_CK_LOW;
                    end
                    PH_CK_LOW: begin
                        res_valid = 1'b1;
                        res_len   = LEN_W'(r_count);
                        if ((r_high | digit) == r_sum) begin
                            res_kind  = KIND_GOOD;
                            res_reply = CH_ACK;
                        end else begin
                            res_kind  = KIND_BAD;
                            res_reply = CH_NAK;
                        end
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_sum   = '0;
                        n_high  = '0;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        n_count = '0;
                        n_sum   = '0;
                        n_high  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_sum       <= '0;
            r_high      <= '0;
        end else begin
            if (rx_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= res_valid;
            end
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_s1_byte <= i_rx_byte;
        end
        if (out_free && res_valid) begin
            r_out_kind  <= res_kind;
            r_out_byte  <= res_byte;
            r_out_len   <= res_len;
            r_out_reply <= res_reply;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_payload_byte  = r_out_byte;
    assign o_packet_length = r_out_len;
    assign o_reply_byte    = r_out_reply;

    // Hunting always starts from a cleared packet context.
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> r_count == '0 && r_sum == '0 && r_high == '0)
        else $error("hunting with stale packet state");

    // A packet end always returns to hunting.
    a_end_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && i_cfg.enable && r_phase == PH_CK_LOW |=> r_phase == PH_HUNT)
        else $error("checksum byte did not close the packet");

    // Payload results carry no length or reply.
    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == KIND_PAYLOAD |-> r_out_len == '0 && r_out_reply == '0)
        else $error("payload result with length or reply");

    // Input stalls only when the input stage holds an item blocked by the output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> r_s1_valid && r_out_valid && i_res_stall)
        else $error("input stalled without a blocked result");

    // A stalled result is not overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_res_stall |=> r_out_valid && $stable(r_out_len))
        else $error("held result lost");

endmodule

[hw/rtl/rsp_packet_deframer_top.sv]
// Top level of the RSP packet deframer: APB registers plus framing engine.
// Depends on rsp_dfr_pkg, rsp_dfr_regs and rsp_dfr_engine.
//
//   channel   signals                                      direction
//   rx        i_rx_valid / o_rx_stall, i_rx_byte            in
//   result    o_res_valid / i_res_stall, kind/payload/len/reply  out
//   config    APB: psel penable pwrite paddr pwdata prdata pready
//
// One byte per cycle while i_res_stall is low; a byte's result passes the input
// register, then the result register.
// The packet state update is a single pass of decode, 8-bit add and limit compare.
// Synchronous active-low reset returns to hunting with empty stages; enable = 0,
// max_length = 4096. A stalled result still lets one more byte be taken.
`timescale 1ns / 1ps

module rsp_packet_deframer_top
    import rsp_dfr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic [LEN_W-1:0]  o_packet_length,
    output logic [BYTE_W-1:0] o_reply_byte
);

    t_cfg cfg;

    rsp_dfr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rsp_dfr_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_rx_valid      (i_rx_valid),
        .i_rx_byte       (i_rx_byte),
        .o_rx_stall      (o_rx_stall),
        .o_res_valid     (o_res_valid),
        .i_res_stall     (i_res_stall),
        .o_kind          (o_kind),
        .o_payload_byte  (o_payload_byte),
        .o_packet_length (o_packet_length),
        .o_reply_byte    (o_reply_byte)
    );

endmodule
